FILE: rtl/rcf_pkg.sv
// Package: word types, register indexes, reset colors and ring constants.
package rcf_pkg;

    localparam int RING_PIXELS = 60;
    localparam int IDX_W       = $clog2(RING_PIXELS);
    localparam int COLOR_W     = 24;
    localparam int CFG_IDX_W   = 3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_PIXELS - 1);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_HOUR_PEAK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOUR_MID    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOUR_DIM    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MINUTE_PEAK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MINUTE_SIDE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_HAND = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INVALID     = 3'd6;

    localparam logic [COLOR_W-1:0] RST_HOUR_PEAK   = 24'hFF0000;
    localparam logic [COLOR_W-1:0] RST_HOUR_MID    = 24'h440000;
    localparam logic [COLOR_W-1:0] RST_HOUR_DIM    = 24'h110000;
    localparam logic [COLOR_W-1:0] RST_MINUTE_PEAK = 24'h00FF00;
    localparam logic [COLOR_W-1:0] RST_MINUTE_SIDE = 24'h002200;
    localparam logic [COLOR_W-1:0] RST_SECOND_HAND = 24'h0000FF;
    localparam logic [COLOR_W-1:0] RST_INVALID     = 24'hFF00FF;

    typedef struct packed {
        logic [4:0] hour_value;
        logic [5:0] minute_value;
        logic [5:0] second_value;
        logic       reading_ok;
    } in_word_t;

    typedef struct packed {
        logic [IDX_W-1:0]   pixel_index;
        logic [COLOR_W-1:0] pixel_color;
        logic               chime_flag;
        logic               frame_last;
    } out_word_t;

    // Decoded reading: hand positions already wrapped onto the ring
    typedef struct packed {
        logic [IDX_W-1:0] hour_pos;
        logic [IDX_W-1:0] minute_pos;
        logic [IDX_W-1:0] second_pos;
        logic             ok;
        logic             chime;
    } reading_t;

    typedef struct packed {
        logic [COLOR_W-1:0] hour_peak;
        logic [COLOR_W-1:0] hour_mid;
        logic [COLOR_W-1:0] hour_dim;
        logic [COLOR_W-1:0] minute_peak;
        logic [COLOR_W-1:0] minute_side;
        logic [COLOR_W-1:0] second_hand;
        logic [COLOR_W-1:0] invalid;
    } colors_t;

endpackage

FILE: rtl/rcf_config_regs.sv
// Color register file written through the configuration channel.
module rcf_config_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rcf_pkg::COLOR_W-1:0]   cfg_data,
    output rcf_pkg::colors_t             colors
);
    import rcf_pkg::*;

    colors_t colors_reg;
    colors_t colors_next;

    assign cfg_ready = 1'b1;
    assign colors    = colors_reg;

    always_comb begin
        colors_next = colors_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_HOUR_PEAK:   colors_next.hour_peak   = cfg_data;
                REG_HOUR_MID:    colors_next.hour_mid    = cfg_data;
                REG_HOUR_DIM:    colors_next.hour_dim    = cfg_data;
                REG_MINUTE_PEAK: colors_next.minute_peak = cfg_data;
                REG_MINUTE_SIDE: colors_next.minute_side = cfg_data;
                REG_SECOND_HAND: colors_next.second_hand = cfg_data;
                REG_INVALID:     colors_next.invalid     = cfg_data;
                default:         colors_next = colors_reg; // drop unknown index
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            colors_reg.hour_peak   <= RST_HOUR_PEAK;
            colors_reg.hour_mid    <= RST_HOUR_MID;
            colors_reg.hour_dim    <= RST_HOUR_DIM;
            colors_reg.minute_peak <= RST_MINUTE_PEAK;
            colors_reg.minute_side <= RST_MINUTE_SIDE;
            colors_reg.second_hand <= RST_SECOND_HAND;
            colors_reg.invalid     <= RST_INVALID;
        end else begin
            colors_reg <= colors_next;
        end
    end

endmodule

FILE: rtl/rcf_reading_reg.sv
// Input register: decodes a time reading into ring positions and holds it.
module rcf_reading_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rcf_pkg::in_word_t s_data,
    input  logic              take,
    output logic              pend_valid,
    output rcf_pkg::reading_t pend
);
    import rcf_pkg::*;

    logic     pend_valid_reg;
    logic     pend_valid_next;
    reading_t pend_reg;
    reading_t decoded;
    logic     accept;

    logic [3:0]       hour12;
    logic [IDX_W-1:0] minute_w;
    logic [IDX_W-1:0] second_w;
    logic [2:0]       hour_step;
    logic [IDX_W-1:0] hour_base;

    assign s_ready    = !pend_valid_reg || take;
    assign accept     = s_valid && s_ready;
    assign pend_valid = pend_valid_reg;
    assign pend       = pend_reg;

    always_comb begin
        // hour mod 12 for 0..31
        if (s_data.hour_value >= 5'd24) begin
            hour12 = 4'(s_data.hour_value - 5'd24);
        end else if (s_data.hour_value >= 5'd12) begin
            hour12 = 4'(s_data.hour_value - 5'd12);
        end else begin
            hour12 = s_data.hour_value[3:0];
        end

        minute_w = (s_data.minute_value >= 6'd60) ? s_data.minute_value - 6'd60
                                                  : s_data.minute_value;
        second_w = (s_data.second_value >= 6'd60) ? s_data.second_value - 6'd60
                                                  : s_data.second_value;

        // minute / 12 for 0..59
        if (minute_w >= 6'd48) begin
            hour_step = 3'd4;
        end else if (minute_w >= 6'd36) begin
            hour_step = 3'd3;
        end else if (minute_w >= 6'd24) begin
            hour_step = 3'd2;
        end else if (minute_w >= 6'd12) begin
            hour_step = 3'd1;
        end else begin
            hour_step = 3'd0;
        end

        // hour12*5 + step stays below 60
        hour_base = {hour12, 2'b00} + {2'b00, hour12};

        decoded.hour_pos   = hour_base + {3'b000, hour_step};
        decoded.minute_pos = minute_w;
        decoded.second_pos = second_w;
        decoded.ok         = s_data.reading_ok;
        decoded.chime      = s_data.reading_ok && (s_data.second_value == 6'd0)
                             && ((s_data.minute_value == 6'd0)
                                 || (s_data.minute_value == 6'd30));
    end

    always_comb begin
        if (accept) begin
            pend_valid_next = 1'b1;
        end else if (take) begin
            pend_valid_next = 1'b0;
        end else begin
            pend_valid_next = pend_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_reg <= decoded;
        end
    end

endmodule

FILE: rtl/rcf_pixel_gen.sv
// Frame sweep: pixel counter, per-pixel hand match and the output register.
module rcf_pixel_gen (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pend_valid,
    input  rcf_pkg::reading_t  pend,
    output logic               take,
    input  rcf_pkg::colors_t   colors,
    output logic               m_valid,
    input  logic               m_ready,
    output rcf_pkg::out_word_t m_data
);
    import rcf_pkg::*;

    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    reading_t         cur_reg, cur_next;
    logic             m_valid_reg, m_valid_next;
    out_word_t        m_data_reg, m_data_next;
    logic             out_free;
    logic             last_pixel;
    logic [COLOR_W-1:0] pixel;

    logic [IDX_W-1:0] d_hour, d_min, d_sec;

    // Distance from a hand position to this pixel, going forward round the ring
    function automatic logic [IDX_W-1:0] ring_dist(input logic [IDX_W-1:0] idx,
                                                   input logic [IDX_W-1:0] pos);
        logic [IDX_W:0] sum;
        sum = {1'b0, idx} + (IDX_W+1)'(RING_PIXELS) - {1'b0, pos};
        if (sum >= (IDX_W+1)'(RING_PIXELS)) begin
            sum = sum - (IDX_W+1)'(RING_PIXELS);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign out_free   = !m_valid_reg || m_ready;
    assign last_pixel = (idx_reg == LAST_IDX);
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    always_comb begin
        d_hour = ring_dist(idx_reg, cur_reg.hour_pos);
        d_min  = ring_dist(idx_reg, cur_reg.minute_pos);
        d_sec  = ring_dist(idx_reg, cur_reg.second_pos);
        pixel  = '0;
        if (!cur_reg.ok) begin
            pixel = colors.invalid;
        end else if (!cur_reg.chime) begin
            if (d_hour == '0) begin
                pixel = pixel | colors.hour_peak;
            end
            if (d_hour == IDX_W'(1) || d_hour == LAST_IDX) begin
                pixel = pixel | colors.hour_mid;
            end
            if (d_hour == IDX_W'(2) || d_hour == IDX_W'(RING_PIXELS - 2)) begin
                pixel = pixel | colors.hour_dim;
            end
            if (d_min == '0) begin
                pixel = pixel | colors.minute_peak;
            end
            if (d_min == IDX_W'(1) || d_min == LAST_IDX) begin
                pixel = pixel | colors.minute_side;
            end
            if (d_sec == '0) begin
                pixel = pixel | colors.second_hand;
            end
        end
    end

    always_comb begin
        busy_next    = busy_reg;
        idx_next     = idx_reg;
        cur_next     = cur_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        take         = 1'b0;

        if (out_free) begin
            m_valid_next = busy_reg;
            if (busy_reg) begin
                m_data_next.pixel_index = idx_reg;
                m_data_next.pixel_color = pixel;
                m_data_next.chime_flag  = cur_reg.chime;
                m_data_next.frame_last  = last_pixel;
                if (last_pixel) begin
                    busy_next = 1'b0;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
        end

        // Load the next reading once the current frame is done or handed off
        if (pend_valid && (!busy_reg || (out_free && last_pixel))) begin
            take      = 1'b1;
            cur_next  = pend;
            idx_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        m_data_reg <= m_data_next;
    end

endmodule

FILE: rtl/ring_clock_face_renderer.sv
// Top level of the ring clock face renderer.
//
//  channel | ports                           | word
//  --------+---------------------------------+-------------------------------
//  input   | s_valid, s_ready, s_data        | one time reading (in_word_t)
//  result  | m_valid, m_ready, m_data        | one ring pixel (out_word_t)
//  config  | cfg_valid, cfg_ready, cfg_index | color register write
//          | cfg_data                        |
//
// Each reading yields 60 pixel words, one per cycle from the pixel counter when
// not stalled, passing the input register, cur_reg and the output register.
// A second reading is held in the input register while a frame is swept and
// starts right after the previous frame's last pixel, with no gap.
// Reset (aresetn low, synchronous) empties both registers and restores the
// reset colors. A stall on m_ready holds the pixel counter and the word.
module ring_clock_face_renderer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  rcf_pkg::in_word_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output rcf_pkg::out_word_t            m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rcf_pkg::COLOR_W-1:0]   cfg_data
);
    import rcf_pkg::*;

    colors_t  colors;
    reading_t pend;
    logic     pend_valid;
    logic     take;

    rcf_config_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .colors    (colors)
    );

    rcf_reading_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (take),
        .pend_valid (pend_valid),
        .pend       (pend)
    );

    rcf_pixel_gen u_gen (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pend_valid (pend_valid),
        .pend       (pend),
        .take       (take),
        .colors     (colors),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

FILE: rtl/rcf_checker.sv
// Port-level checks on the renderer, bound to the top level.
module rcf_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input rcf_pkg::out_word_t            m_data
);
    import rcf_pkg::*;

    // No word right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word present after reset");

    // Within a frame the next pixel follows at once, index advancing by one
    a_frame_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.frame_last) |=>
        (m_valid && m_data.pixel_index == $past(m_data.pixel_index) + IDX_W'(1)))
        else $error("frame broken or index skipped");

    // Last marker sits exactly on the final ring position
    a_last_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.frame_last == (m_data.pixel_index == LAST_IDX)))
        else $error("frame_last does not match pixel index");

    // A chime frame is blank
    a_chime_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.chime_flag) |-> (m_data.pixel_color == '0))
        else $error("chime frame carries color");

    // Stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result word changed");

endmodule

bind ring_clock_face_renderer rcf_checker u_rcf_checker (.*);
